### rtl/a85_pkg.sv
// Package of the ASCII85 stream encoder: payload types and radix constants.
// No dependencies; every other file of the block but a85_if imports it.
package a85_pkg;

    localparam logic [6:0]  RADIX      = 7'd85;
    localparam logic [12:0] RADIX_SQ   = 13'd7225;
    localparam logic [6:0]  CHAR_BASE  = 7'd33;
    localparam logic [6:0]  ZERO_CHAR  = 7'd122;

    // Reciprocals rounded down: the estimate is the true quotient or one less.
    localparam logic [19:0] RECIP_SQ_32 = 20'((64'd1 << 32) / 64'd7225);
    localparam logic [13:0] RECIP_20    = 14'((32'd1 << 20) / 32'd85);
    localparam logic [6:0]  RECIP_13    = 7'((32'd1 << 13) / 32'd85);

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  nchars;
        logic        zero;
    } t_grp;

    typedef struct packed {
        logic [4:0][6:0] dig;
        logic [2:0]      nchars;
        logic            zero;
    } t_digits;

    typedef struct packed {
        logic [13:0] quo;
        logic [6:0]  rem;
    } t_qr;

endpackage

### rtl/a85_if.sv
// Stream interfaces of the ASCII85 encoder: byte input and character output.
// No dependencies.
interface a85_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface a85_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink (input valid, input out_char, input run_last, output ready);
endinterface

### rtl/ascii85_stream_encoder.sv
// Top level of the ASCII85 stream encoder: packer, base-85 pipeline, serializer.
// Depends on a85_pkg, a85_if, a85_packer, a85_radix and a85_serial.
//
//   Channel  Direction  Payload                         One item
//   i_in     in         data_byte[7:0], end_of_stream   one raw byte
//   o_out    out        out_char[6:0], run_last         one encoded character
//
// A byte can be accepted in every cycle unless a stall holds the pipeline. The first
// character of a group is offered after its closing byte passes the packer, six stages, serializer.
// The output sends one character per cycle while o_out.ready is high; a full group has five
// characters, so that channel sets the sustained rate.
// Reset clears the pending partial group and empties the pipeline.
// A stall on o_out freezes all six stages while the last one holds a group, and
// i_in.ready then drops as soon as the packer holds a finished group.
module ascii85_stream_encoder
    import a85_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    a85_in_if.sink    i_in,
    a85_out_if.source o_out
);

    logic    pk_valid;
    logic    rx_ready;
    t_grp    pk_grp;
    logic    rx_valid;
    logic    sr_ready;
    t_digits rx_dig;

    a85_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_dn_ready (rx_ready),
        .o_valid    (pk_valid),
        .o_grp      (pk_grp)
    );

    a85_radix u_radix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (pk_valid),
        .o_ready    (rx_ready),
        .i_grp      (pk_grp),
        .o_valid    (rx_valid),
        .i_dn_ready (sr_ready),
        .o_dig      (rx_dig)
    );

    a85_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rx_valid),
        .o_ready (sr_ready),
        .i_dig   (rx_dig),
        .o_out   (o_out)
    );

endmodule

### rtl/a85_packer.sv
// Byte packer: collects input bytes into big-endian groups and registers each
// finished or flushed group, zero-padded. Depends on a85_pkg and a85_in_if.
module a85_packer
    import a85_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    a85_in_if.sink   i_in,
    input  logic     i_dn_ready,
    output logic     o_valid,
    output t_grp     o_grp
);

    logic [23:0] r_grp, n_grp;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_vld, n_vld;
    t_grp        r_out, n_out;
    logic        accept;
    logic        push;
    logic [31:0] word;

    assign i_in.ready = !r_vld || i_dn_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign push       = (r_cnt == 2'd3) || i_in.end_of_stream;
    assign word       = {r_grp, i_in.data_byte};

    always_comb begin
        n_grp = r_grp;
        n_cnt = r_cnt;
        n_vld = r_vld && !i_dn_ready;
        n_out = r_out;
        unique case (r_cnt)
            2'd0: n_out.value = {i_in.data_byte, 24'd0};
            2'd1: n_out.value = {r_grp[7:0], i_in.data_byte, 16'd0};
            2'd2: n_out.value = {r_grp[15:0], i_in.data_byte, 8'd0};
            2'd3: n_out.value = word;
            default: n_out.value = word;
        endcase
        n_out.zero   = (r_cnt == 2'd3) && (word == 32'd0);
        n_out.nchars = n_out.zero ? 3'd1 : ({1'b0, r_cnt} + 3'd2);
        if (accept) begin
            if (push) begin
                n_grp = 24'd0;
                n_cnt = 2'd0;
                n_vld = 1'b1;
            end else begin
                n_grp = word[23:0];
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= 24'd0;
            r_cnt <= 2'd0;
            r_vld <= 1'b0;
        end else begin
            r_grp <= n_grp;
            r_cnt <= n_cnt;
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && push) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld;
    assign o_grp   = r_out;

endmodule

### rtl/a85_radix.sv
// Base-85 conversion pipeline: six stages that split a 32-bit group into five
// digits by reciprocal multiplication with one correction. Depends on a85_pkg.
module a85_radix
    import a85_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_grp    i_grp,
    output logic    o_valid,
    input  logic    i_dn_ready,
    output t_digits o_dig
);

    function automatic t_qr fix85(input logic [19:0] num, input logic [13:0] est);
        logic [19:0] t;
        t_qr         res;
        t = num - ({6'd0, est} * {13'd0, RADIX});
        if (t >= {13'd0, RADIX}) begin
            res.quo = est + 14'd1;
            res.rem = 7'(t - {13'd0, RADIX});
        end else begin
            res.quo = est;
            res.rem = 7'(t);
        end
        return res;
    endfunction

    logic            en;
    logic [5:0]      r_vld;
    logic [5:0][2:0] r_nch;
    logic [5:0]      r_zero;

    logic [31:0]     r0_v;
    logic [51:0]     r0_p;
    logic [19:0]     r1_q;
    logic [12:0]     r1_r;
    logic [19:0]     r2_q;
    logic [12:0]     r2_r;
    logic [33:0]     r2_pq;
    logic [19:0]     r2_pr;
    logic [12:0]     r3_q2;
    logic [6:0]      r3_d2, r3_d3, r3_d4;
    logic [12:0]     r4_q2;
    logic [19:0]     r4_p;
    logic [6:0]      r4_d2, r4_d3, r4_d4;
    logic [4:0][6:0] r5_d;

    logic [19:0]     s1_est;
    logic [32:0]     s1_t;
    logic [13:0]     s1_rem;
    logic [19:0]     n1_q;
    logic [12:0]     n1_r;
    t_qr             s3_q, s3_r, s5_q;

    assign en      = !r_vld[5] || i_dn_ready;
    assign o_ready = en;

    always_comb begin
        s1_est = r0_p[51:32];
        s1_t   = {1'b0, r0_v} - ({13'd0, s1_est} * {20'd0, RADIX_SQ});
        s1_rem = s1_t[13:0];
        if (s1_rem >= {1'b0, RADIX_SQ}) begin
            n1_q = s1_est + 20'd1;
            n1_r = 13'(s1_rem - {1'b0, RADIX_SQ});
        end else begin
            n1_q = s1_est;
            n1_r = s1_rem[12:0];
        end
        s3_q = fix85(r2_q, r2_pq[33:20]);
        s3_r = fix85({7'd0, r2_r}, {7'd0, r2_pr[19:13]});
        s5_q = fix85({7'd0, r4_q2}, {7'd0, r4_p[19:13]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 6'd0;
        end else if (en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nch  <= {r_nch[4:0], i_grp.nchars};
            r_zero <= {r_zero[4:0], i_grp.zero};
            r0_v   <= i_grp.value;
            r0_p   <= {20'd0, i_grp.value} * {32'd0, RECIP_SQ_32};
            r1_q   <= n1_q;
            r1_r   <= n1_r;
            r2_q   <= r1_q;
            r2_r   <= r1_r;
            r2_pq  <= {14'd0, r1_q} * {20'd0, RECIP_20};
            r2_pr  <= {7'd0, r1_r} * {13'd0, RECIP_13};
            r3_q2  <= s3_q.quo[12:0];
            r3_d2  <= s3_q.rem;
            r3_d3  <= s3_r.quo[6:0];
            r3_d4  <= s3_r.rem;
            r4_q2  <= r3_q2;
            r4_p   <= {7'd0, r3_q2} * {13'd0, RECIP_13};
            r4_d2  <= r3_d2;
            r4_d3  <= r3_d3;
            r4_d4  <= r3_d4;
            r5_d   <= {s5_q.quo[6:0], s5_q.rem, r4_d2, r4_d3, r4_d4};
        end
    end

    assign o_valid      = r_vld[5];
    assign o_dig.dig    = r5_d;
    assign o_dig.nchars = r_nch[5];
    assign o_dig.zero   = r_zero[5];

endmodule

### rtl/a85_serial.sv
// Character serializer: holds one converted group and sends its characters
// one item at a time. Depends on a85_pkg and a85_out_if.
module a85_serial
    import a85_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_digits  i_dig,
    a85_out_if.source o_out
);

    logic            r_busy;
    logic [2:0]      r_idx;
    logic [2:0]      r_n;
    logic [6:0]      r_chars [0:4];
    logic            is_last;
    logic            sent;
    logic            load;

    assign is_last = (r_idx == (r_n - 3'd1));
    assign sent    = r_busy && o_out.ready;
    assign o_ready = !r_busy || (o_out.ready && is_last);
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (sent && is_last) begin
            r_busy <= 1'b0;
        end else if (sent) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_n        <= i_dig.nchars;
            r_chars[0] <= i_dig.zero ? ZERO_CHAR : (i_dig.dig[4] + CHAR_BASE);
            r_chars[1] <= i_dig.dig[3] + CHAR_BASE;
            r_chars[2] <= i_dig.dig[2] + CHAR_BASE;
            r_chars[3] <= i_dig.dig[1] + CHAR_BASE;
            r_chars[4] <= i_dig.dig[0] + CHAR_BASE;
        end
    end

    assign o_out.valid    = r_busy;
    assign o_out.out_char = r_chars[r_idx];
    assign o_out.run_last = is_last;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_n))
        else $error("Character index beyond the group length.");

    a_zero_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_dig.zero) |=> (r_n == 3'd1))
        else $error("Zero group loaded with more than one character.");

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_n >= 3'd1 && r_n <= 3'd5))
        else $error("Group length out of range.");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_out.ready) |=> ($stable(r_idx) && r_busy))
        else $error("Serializer moved while the output was stalled.");
`endif

endmodule

### verif/tb_ascii85_stream_encoder.sv
// Self-checking testbench of the ASCII85 stream encoder: bursty bytes in, stalled characters out.
// Each expected character comes from a predictor in this file and is checked against the output.
// Depends on a85_pkg, a85_if and the ascii85_stream_encoder top level.
`timescale 1ns / 1ps

module tb_ascii85_stream_encoder;
    import a85_pkg::*;

    localparam int unsigned GROUP_BYTES   = 4;
    localparam int unsigned RANDOM_ITEMS  = 120;
    localparam int unsigned HOLD_AT_ITEM  = 60;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned TAIL_CYCLES   = 40;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
        logic       drain_first;
    } t_byte_item;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_char_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    a85_in_if  in_bus ();
    a85_out_if out_bus ();

    ascii85_stream_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_byte_item  byte_queue[$];
    t_char_item  char_queue[$];
    int unsigned error_count = 0;
    int unsigned bytes_taken = 0;

    logic [23:0] pend_bytes = '0;
    logic [1:0]  pend_count = '0;

    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic void push_group_chars(input logic [31:0] value,
                                             input int unsigned nbytes);
        logic [31:0] rest;
        logic [6:0]  digit [5];
        t_char_item  c;
        int unsigned n;
        if (nbytes == GROUP_BYTES && value == '0) begin
            c.ch = ZERO_CHAR;
            c.last = 1'b1;
            char_queue.push_back(c);
            return;
        end
        rest = value;
        for (int i = 4; i >= 0; i--) begin
            digit[i] = 7'(rest % 32'(RADIX)) + CHAR_BASE;
            rest = rest / 32'(RADIX);
        end
        n = nbytes + 1;
        for (int unsigned i = 0; i < n; i++) begin
            c.ch = digit[i];
            c.last = (i == n - 1);
            char_queue.push_back(c);
        end
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic eos);
        int unsigned cnt;
        logic [31:0] value;
        cnt = pend_count + 1;
        value = {pend_bytes, b};
        if (cnt == GROUP_BYTES || eos) begin
            value = value << ((GROUP_BYTES - cnt) * 8);
            push_group_chars(value, cnt);
            pend_bytes = '0;
            pend_count = '0;
        end else begin
            pend_bytes = value[23:0];
            pend_count = 2'(cnt);
        end
    endfunction

    // Sender: bursts of items with random gaps; an item marked drain_first waits
    // until every expected character has been seen.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            in_bus.data_byte <= '0;
            in_bus.end_of_stream <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                encode_byte(in_bus.data_byte, in_bus.end_of_stream);
                bytes_taken++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_bus.valid <= 1'b0;
                end else if (byte_queue.size() == 0) begin
                    in_bus.valid <= 1'b0;
                end else if (byte_queue[0].drain_first && char_queue.size() != 0) begin
                    in_bus.valid <= 1'b0;
                end else begin
                    in_bus.valid <= 1'b1;
                    in_bus.data_byte <= byte_queue[0].data_byte;
                    in_bus.end_of_stream <= byte_queue[0].end_of_stream;
                    void'(byte_queue.pop_front());
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: checks each character, then picks its next ready value.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (char_queue.size() == 0) begin
                    flag_error($sformatf("unexpected character 0x%02h", out_bus.out_char));
                end else begin
                    if (out_bus.out_char !== char_queue[0].ch)
                        flag_error($sformatf("out_char 0x%02h, expected 0x%02h",
                                             out_bus.out_char, char_queue[0].ch));
                    if (out_bus.run_last !== char_queue[0].last)
                        flag_error($sformatf("run_last %b, expected %b",
                                             out_bus.run_last, char_queue[0].last));
                    void'(char_queue.pop_front());
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (!hold_done && bytes_taken >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 60);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    STALL_NONE: begin
                        out_bus.ready <= 1'b1;
                    end
                    STALL_COIN: begin
                        out_bus.ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        out_bus.ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    task automatic add_item(input logic [7:0] b, input logic eos, input logic drain = 1'b0);
        t_byte_item it;
        it.data_byte = b;
        it.end_of_stream = eos;
        it.drain_first = drain;
        byte_queue.push_back(it);
    endtask

    task automatic add_stream(input int unsigned nbytes, input bit close, input bit drain);
        bit          zero_grp;
        int unsigned pick;
        logic [7:0]  b;
        zero_grp = 1'b0;
        for (int unsigned i = 0; i < nbytes; i++) begin
            if (i % GROUP_BYTES == 0)
                zero_grp = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (zero_grp || pick == 0)
                b = 8'h00;
            else if (pick == 1)
                b = 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            add_item(b, close && (i == nbytes - 1), drain && (i == 0));
        end
    endtask

    initial begin
        int unsigned queued;
        int unsigned n;
        bit          close;
        bit          drained;

        // Zero group, all-ones group, and short flushes that must not use the zero shorthand.
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h00, 1'b1);
        add_item(8'h80, 1'b0);
        add_item(8'h7F, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b1);
        // Two streams that end on a full group, nonzero and then zero, then a one-byte stream.
        add_item(8'h01, 1'b0);
        add_item(8'hA5, 1'b0);
        add_item(8'h5A, 1'b0);
        add_item(8'hFE, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b1);
        add_item(8'hFF, 1'b1);

        queued = 0;
        drained = 1'b0;
        add_stream(4, 1'b1, 1'b1);
        while (queued < RANDOM_ITEMS) begin
            n = $urandom_range(1, 12);
            close = ($urandom_range(0, 7) != 0) || (queued + n >= RANDOM_ITEMS);
            add_stream(n, close, !drained && queued >= RANDOM_ITEMS / 2);
            if (queued >= RANDOM_ITEMS / 2)
                drained = 1'b1;
            queued += n;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_bus.valid)
            @(posedge i_clk);
        while (char_queue.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_ascii85_stream_encoder: clean");
        end else begin
            $display("tb_ascii85_stream_encoder: errors");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TIMEOUT with %0d characters outstanding", char_queue.size());
        $display("tb_ascii85_stream_encoder: errors");
        $finish;
    end

endmodule
